// ----- rtl/fpmo_pkg.sv -----
// Package for the feedback phase-modulation sine oscillator.
// Holds the sequencer state type and the fixed arithmetic constants.
// No dependencies.
`default_nettype none
package fpmo_pkg;

  localparam int MUL_W = 32;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RDA, S_RDB, S_BL2, S_BL3, S_FB, S_TH,
    S_K0, S_K1, S_K2, S_Z, S_SQ, S_Z2, S_HM, S_HS, S_FM, S_FIN
  } state_t;

  localparam logic [31:0] TURN_K  = 32'd683565276;
  localparam logic [31:0] COEF_C9 = 32'd172274;

  localparam logic [31:0] HORNER_COEF [4] = '{
    32'd5026992, 32'd85569306, 32'd693598670, 32'd1686629713
  };

  localparam logic [30:0] Q30_ONE = 31'd1073741824;

endpackage
`default_nettype wire

// ----- rtl/feedback_pm_sine_osc.sv -----
// Feedback phase-modulation sine oscillator, top level.
// One item in flight: a new input beat is taken only once the last result has been
//   written to the output register (one shared multiplier, Horner sine over 4 steps).
// Reset: synchronous; a clearing pass zeroes all MAX_DELAY+1 history entries
//   before the first input beat is taken.
// Depends on fpmo_pkg and fpmo_mul.
`default_nettype none
module feedback_pm_sine_osc #(
  parameter int MAX_DELAY = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_phase,
  input  wire logic signed [15:0] in_fold,
  input  wire logic signed [15:0] in_delay_amount,
  input  wire logic signed [15:0] in_feedback_gain,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_sine_out
);
  import fpmo_pkg::*;

  localparam int DEPTH = MAX_DELAY + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_DELAY);

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [IDX_W-1:0] wi_r, wi_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       k_r, k_nxt;

  logic signed [15:0] phase_r, fold_r, gain_r, out_r;
  logic signed [8:0]  frac_r;
  logic [IDX_W-1:0]   ia_r;
  logic signed [15:0] rd_r;
  logic signed [63:0] acc_r;
  logic signed [33:0] theta_r;
  logic [1:0]         quad_r;
  logic [30:0]        z_r, z2_r;
  logic [31:0]        p_r;

  logic [15:0] hist_mem [DEPTH];

  logic signed [MUL_W-1:0]   op_a, op_b;
  logic signed [2*MUL_W-1:0] prod_r;

  fpmo_mul u_mul (.clk(clk), .op_a(op_a), .op_b(op_b), .prod_r(prod_r));

  // delay split and read address for the newest item
  logic signed [8:0]  wh;
  logic signed [8:0]  frac_in;
  logic [IDX_W-1:0]   whole_c;
  logic signed [IDX_W+1:0] diff;
  logic [IDX_W-1:0]   ia_in, ib;
  logic               round_up;

  always_comb begin
    round_up = in_delay_amount[15] && (in_delay_amount[7:0] != 8'd0);
    wh = {in_delay_amount[15], in_delay_amount[15:8]} + (round_up ? 9'sd1 : 9'sd0);
    frac_in = {round_up, in_delay_amount[7:0]};
    if (wh < 9'sd1) begin
      whole_c = IDX_W'(1);
    end else if (int'(wh) > MAX_DELAY) begin
      whole_c = LAST;
    end else begin
      whole_c = IDX_W'(wh[7:0]);
    end
    diff = $signed({2'b00, wi_r}) - $signed({2'b00, whole_c});
    ia_in = diff[IDX_W+1] ? IDX_W'(diff + (IDX_W+2)'(DEPTH)) : diff[IDX_W-1:0];
    ib = (ia_r == '0) ? LAST : ia_r - IDX_W'(1);
  end

  // sequencer
  logic signed [9:0]  w_a;
  logic signed [63:0] fb_sum;
  logic [31:0]        turn;
  logic [31:0]        q_fin;
  logic [16:0]        y_fin;
  logic signed [15:0] s_fin;
  logic               fin_go;

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    wi_nxt        = wi_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = (state_r == S_IDLE);
    op_a          = '0;
    op_b          = '0;
    w_a           = 10'sd256 - {frac_r[8], frac_r};
    fb_sum        = (prod_r + 64'sd2048) >>> 12;
    turn          = acc_r[54:23];
    q_fin         = prod_r[61:30];
    y_fin         = 17'((q_fin + 32'd16384) >> 15);
    if (y_fin > 17'd32767) begin
      s_fin = 16'sd32767;
    end else begin
      s_fin = $signed(y_fin[15:0]);
    end
    if (quad_r[1]) begin
      s_fin = -s_fin;
    end
    fin_go = !out_valid_r || out_ready;
    unique case (state_r)
      S_CLEAR: begin
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RDA;
        end
      end
      S_RDA: state_nxt = S_RDB;
      S_RDB: begin
        op_a = MUL_W'(rd_r);
        op_b = MUL_W'(w_a);
        state_nxt = S_BL2;
      end
      S_BL2: begin
        op_a = MUL_W'(rd_r);
        op_b = MUL_W'(frac_r);
        state_nxt = S_BL3;
      end
      S_BL3: begin
        op_a = MUL_W'(fold_r);
        op_b = MUL_W'(phase_r);
        state_nxt = S_FB;
      end
      S_FB: begin
        op_a = acc_r[MUL_W-1:0];
        op_b = MUL_W'(gain_r);
        state_nxt = S_TH;
      end
      S_TH: state_nxt = S_K0;
      S_K0: begin
        op_a = $signed({15'd0, theta_r[16:0]});
        op_b = $signed(TURN_K);
        state_nxt = S_K1;
      end
      S_K1: begin
        op_a = MUL_W'($signed(theta_r[33:17]));
        op_b = $signed(TURN_K);
        state_nxt = S_K2;
      end
      S_K2: state_nxt = S_Z;
      S_Z:  state_nxt = S_SQ;
      S_SQ: begin
        op_a = $signed({1'b0, z_r});
        op_b = $signed({1'b0, z_r});
        state_nxt = S_Z2;
      end
      S_Z2: begin
        k_nxt = '0;
        state_nxt = S_HM;
      end
      S_HM: begin
        op_a = $signed({1'b0, z2_r});
        op_b = $signed(p_r);
        state_nxt = S_HS;
      end
      S_HS: begin
        k_nxt = k_r + 2'd1;
        state_nxt = (k_r == 2'd3) ? S_FM : S_HM;
      end
      S_FM: begin
        op_a = $signed({1'b0, z_r});
        op_b = $signed(p_r);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        op_a = $signed({1'b0, z_r});
        op_b = $signed(p_r);
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          wi_nxt = (wi_r == LAST) ? '0 : wi_r + IDX_W'(1);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      wi_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      wi_r        <= wi_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // history ring
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa, mem_ra;
  logic [15:0]      mem_wd;

  always_comb begin
    mem_we = (state_r == S_CLEAR) || (state_r == S_FIN && fin_go);
    mem_wa = (state_r == S_CLEAR) ? clr_idx_r : wi_r;
    mem_wd = (state_r == S_CLEAR) ? 16'd0 : s_fin;
    mem_ra = (state_r == S_RDB) ? ib : ia_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_wa] <= mem_wd;
    end
    rd_r <= $signed(hist_mem[mem_ra]);
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        phase_r <= in_phase;
        fold_r  <= in_fold;
        gain_r  <= in_feedback_gain;
        frac_r  <= frac_in;
        ia_r    <= ia_in;
      end
      S_BL2: acc_r <= prod_r;
      S_BL3: acc_r <= acc_r + prod_r;
      S_FB:  theta_r <= 34'(prod_r);
      S_TH:  theta_r <= theta_r + 34'(fb_sum);
      S_K1:  acc_r <= prod_r;
      S_K2:  acc_r <= acc_r + (prod_r <<< 17);
      S_Z: begin
        quad_r <= turn[31:30];
        z_r    <= turn[30] ? Q30_ONE - {1'b0, turn[29:0]} : {1'b0, turn[29:0]};
      end
      S_Z2: begin
        z2_r <= prod_r[60:30];
        p_r  <= COEF_C9;
      end
      S_HS:  p_r <= HORNER_COEF[k_r] - prod_r[61:30];
      S_FIN: if (fin_go) out_r <= s_fin;
      default: ;
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_sine_out = out_r;

endmodule
`default_nettype wire

// ----- rtl/fpmo_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on fpmo_pkg for the operand width.
`default_nettype none
module fpmo_mul (
  input  wire logic                                clk,
  input  wire logic signed [fpmo_pkg::MUL_W-1:0]   op_a,
  input  wire logic signed [fpmo_pkg::MUL_W-1:0]   op_b,
  output logic signed [2*fpmo_pkg::MUL_W-1:0]      prod_r
);
  import fpmo_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule
`default_nettype wire
